>>> src/svts_pkg.sv
package svts_pkg;

    // Longest source that the offsets can count; offsets stop one below it.
    localparam int unsigned MAX_SCAN_BYTES = 65536;
    localparam int unsigned OFFSET_CAP_INT =
        ((MAX_SCAN_BYTES - 1) < 65535) ? (MAX_SCAN_BYTES - 1) : 65535;
    localparam logic [15:0] OFFSET_CAP = 16'(OFFSET_CAP_INT);

    localparam logic [15:0] MIN_VERSION_RESET = 16'd120;
    localparam int unsigned TOKEN_LEN = 8;
    localparam logic [2:0]  TOKEN_LAST = 3'(TOKEN_LEN - 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_VERSION  = 2'd0;
    localparam logic [1:0] REG_FORCE_ENABLE = 2'd1;
    localparam logic [1:0] REG_FORCE_VALUE  = 2'd2;

    typedef enum logic [3:0] {
        MODE_BLANK  = 4'd0,
        MODE_LINE   = 4'd1,
        MODE_BLOCK  = 4'd2,
        MODE_MATCH  = 4'd3,
        MODE_SPACE  = 4'd4,
        MODE_SIGN   = 4'd5,
        MODE_DIGITS = 4'd6,
        MODE_DONE   = 4'd7,
        MODE_FAIL   = 4'd8
    } scan_mode_t;

    // Scan state carried from one byte to the next. The byte held for
    // lookahead is always a known character in the mode it is held in, so
    // only its valid flag is kept.
    typedef struct packed {
        scan_mode_t  mode;
        logic        held_valid;
        logic [15:0] byte_offset;
        logic [2:0]  match_index;
        logic [15:0] number_accum;
        logic        number_negative;
        logic [15:0] token_offset;
        logic        saturated;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:            MODE_BLANK,
        held_valid:      1'b0,
        byte_offset:     16'd0,
        match_index:     3'd0,
        number_accum:    16'd0,
        number_negative: 1'b0,
        token_offset:    16'd0,
        saturated:       1'b0
    };

    // Characters of the version directive, by position.
    function automatic logic [7:0] token_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h23; // '#'
            3'd1:    c = 8'h76; // 'v'
            3'd2:    c = 8'h65; // 'e'
            3'd3:    c = 8'h72; // 'r'
            3'd4:    c = 8'h73; // 's'
            3'd5:    c = 8'h69; // 'i'
            3'd6:    c = 8'h6F; // 'o'
            default: c = 8'h6E; // 'n'
        endcase
        return c;
    endfunction

endpackage

>>> src/svts_if.sv
interface svts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       last;

    modport source (output valid, output src_byte, output last, input ready);
    modport sink   (input valid, input src_byte, input last, output ready);
endinterface

interface svts_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] version;
    logic        version_line;
    logic        token_found;
    logic [15:0] blank_start;
    logic [15:0] blank_end;
    logic        overflow;

    modport source (
        output valid, output version, output version_line, output token_found,
        output blank_start, output blank_end, output overflow, input ready
    );
    modport sink (
        input valid, input version, input version_line, input token_found,
        input blank_start, input blank_end, input overflow, output ready
    );
endinterface

>>> src/shader_version_token_scanner.sv
// Channel  Dir  Fields                                              Word
// -------  ---  --------------------------------------------------  ---------------------
// src      in   src_byte[7:0], last                                 one source byte
// res      out  version[15:0], version_line, token_found,           one summary per source
//               blank_start[15:0], blank_end[15:0], overflow
// cfg      in   cfg_write, cfg_index[1:0], cfg_data[15:0]           one register write
//
// One source byte is taken every cycle while src is not stalled. The scan update for a
// byte is one pass through the step logic between the scan state register and the result
// register, so the summary is on res in the cycle after the byte that ends the source.
// Reset (rst_n low, asynchronous) clears the scan state, empties the result register and
// loads min_version with 120, force_enable and force_value with zero.
// src stalls only while a summary waits in the result register and res is not ready.
module shader_version_token_scanner (
    input  logic              clk,
    input  logic              rst_n,
    svts_byte_if.sink         src,
    svts_result_if.source     res,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import svts_pkg::*;

    // Configuration registers.
    logic [15:0] min_version_reg;
    logic        force_enable_reg;
    logic [15:0] force_value_reg;

    // Scan state, and its value after the byte that is being accepted.
    scan_state_t scan_reg;
    scan_state_t scan_next;
    scan_state_t stepped;

    // Result register.
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [15:0] version_reg;
    logic [15:0] version_next;
    logic        token_found_reg;
    logic        token_found_next;
    logic [15:0] blank_start_reg;
    logic [15:0] blank_start_next;
    logic [15:0] blank_end_reg;
    logic [15:0] blank_end_next;
    logic        overflow_reg;

    logic accept;
    logic src_end;
    logic byte_scanned;

    // A zero byte ends the source without being scanned itself.
    assign byte_scanned = (src.src_byte != 8'd0);
    assign src_end      = !byte_scanned || src.last;

    // The result register can be refilled in the same cycle it is emptied.
    assign src.ready = !res_valid_reg || res.ready;
    assign accept    = src.valid && src.ready;

    svts_scan_step u_step (
        .cur      (scan_reg),
        .src_byte (src.src_byte),
        .nxt      (stepped)
    );

    always_comb
    begin
        scan_state_t after;
        logic        found;

        after = byte_scanned ? stepped : scan_reg;
        found = (after.mode == MODE_DIGITS) || (after.mode == MODE_DONE);

        // Floor rule: a negative number never beats the floor.
        version_next = min_version_reg;
        if (found && !after.number_negative && after.number_accum > min_version_reg) begin
            version_next = after.number_accum;
        end
        if (force_enable_reg) begin
            version_next = force_value_reg;
        end

        token_found_next = found;
        blank_start_next = found ? after.token_offset : 16'd0;
        blank_end_next   = found ? after.byte_offset : 16'd0;

        // At the end of a source the scan returns to its reset state for the next one.
        scan_next = scan_reg;
        if (accept) begin
            scan_next = src_end ? SCAN_RESET : after;
        end

        res_valid_next = res_valid_reg && !res.ready;
        if (accept && src_end) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_version_reg  <= MIN_VERSION_RESET;
            force_enable_reg <= 1'b0;
            force_value_reg  <= 16'd0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_MIN_VERSION:  min_version_reg  <= cfg_data;
                REG_FORCE_ENABLE: force_enable_reg <= cfg_data[0];
                REG_FORCE_VALUE:  force_value_reg  <= cfg_data;
                default:          min_version_reg  <= min_version_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scan_reg      <= SCAN_RESET;
            res_valid_reg <= 1'b0;
        end else begin
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload is loaded only with the word that ends a source.
    always_ff @(posedge clk)
    begin
        if (accept && src_end) begin
            version_reg     <= version_next;
            token_found_reg <= token_found_next;
            blank_start_reg <= blank_start_next;
            blank_end_reg   <= blank_end_next;
            overflow_reg    <= byte_scanned ? stepped.saturated : scan_reg.saturated;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.version      = version_reg;
    assign res.version_line = (version_reg != 16'd0);
    assign res.token_found  = token_found_reg;
    assign res.blank_start  = blank_start_reg;
    assign res.blank_end    = blank_end_reg;
    assign res.overflow     = overflow_reg;

`ifndef SYNTHESIS
    // The word that ends a source always leaves a summary behind.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_end |=> res_valid_reg)
        else $error("source ended without a summary");

    // The scan starts over after every source.
    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_end |=> scan_reg.mode == MODE_BLANK && scan_reg.byte_offset == 16'd0
            && !scan_reg.held_valid && !scan_reg.saturated)
        else $error("scan state not cleared after end of source");

    // A found token never ends before it begins.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && token_found_reg |-> blank_end_reg >= blank_start_reg)
        else $error("blank span ends before it starts");
`endif

endmodule

>>> src/svts_scan_step.sv
module svts_scan_step (
    input  svts_pkg::scan_state_t cur,
    input  logic [7:0]            src_byte,
    output svts_pkg::scan_state_t nxt
);
    import svts_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic        is_digit;
    logic        is_blank;
    logic        is_num_space;
    logic [19:0] digit_sum;
    logic [15:0] digit_accum;
    logic        digit_sat;

    always_comb
    begin
        is_digit     = src_byte inside {[CH_ZERO:CH_NINE]};
        is_blank     = src_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
        is_num_space = src_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    end

    // Accumulator times ten plus the digit, saturating at the 16-bit limit.
    always_comb
    begin
        digit_sum = {1'b0, cur.number_accum, 3'b000} + {3'b000, cur.number_accum, 1'b0}
                  + {16'd0, src_byte[3:0]};
        digit_sat = (digit_sum[19:16] != 4'd0);
        digit_accum = digit_sat ? 16'hFFFF : digit_sum[15:0];
    end

    always_comb
    begin
        nxt = cur;
        if (cur.mode == MODE_DONE || cur.mode == MODE_FAIL) begin
            nxt = cur;
        end else if (cur.mode == MODE_DIGITS && !is_digit) begin
            nxt.mode = MODE_DONE;
        end else begin
            if (cur.byte_offset < OFFSET_CAP) begin
                nxt.byte_offset = cur.byte_offset + 16'd1;
            end else begin
                nxt.saturated = 1'b1;
            end

            case (cur.mode)
                MODE_BLANK:
                begin
                    if (cur.held_valid) begin
                        nxt.held_valid = 1'b0;
                        if (src_byte == CH_STAR) begin
                            nxt.mode = MODE_BLOCK;
                        end else if (src_byte == CH_SLASH) begin
                            nxt.mode = MODE_LINE;
                        end else begin
                            nxt.mode = MODE_FAIL;
                        end
                    end else if (src_byte == CH_SLASH) begin
                        nxt.held_valid = 1'b1;
                    end else if (is_blank) begin
                        nxt.mode = MODE_BLANK;
                    end else if (src_byte == token_char(3'd0)) begin
                        nxt.mode         = MODE_MATCH;
                        nxt.match_index  = 3'd1;
                        nxt.token_offset = cur.byte_offset;
                    end else begin
                        nxt.mode = MODE_FAIL;
                    end
                end
                MODE_LINE:
                begin
                    if (src_byte == CH_LF) begin
                        nxt.mode = MODE_BLANK;
                    end
                end
                MODE_BLOCK:
                begin
                    if (cur.held_valid && src_byte == CH_SLASH) begin
                        nxt.held_valid = 1'b0;
                        nxt.mode       = MODE_BLANK;
                    end else begin
                        nxt.held_valid = (src_byte == CH_STAR);
                    end
                end
                MODE_MATCH:
                begin
                    if (src_byte == token_char(cur.match_index)) begin
                        if (cur.match_index == TOKEN_LAST) begin
                            nxt.match_index = 3'd0;
                            nxt.mode        = MODE_SPACE;
                        end else begin
                            nxt.match_index = cur.match_index + 3'd1;
                        end
                    end else begin
                        nxt.mode = MODE_FAIL;
                    end
                end
                MODE_SPACE:
                begin
                    if (is_num_space) begin
                        nxt.mode = MODE_SPACE;
                    end else if (src_byte == CH_PLUS || src_byte == CH_MINUS) begin
                        nxt.number_negative = (src_byte == CH_MINUS);
                        nxt.mode            = MODE_SIGN;
                    end else if (is_digit) begin
                        nxt.number_accum = digit_accum;
                        nxt.saturated    = nxt.saturated | digit_sat;
                        nxt.mode         = MODE_DIGITS;
                    end else begin
                        nxt.mode = MODE_FAIL;
                    end
                end
                MODE_SIGN:
                begin
                    if (is_digit) begin
                        nxt.number_accum = digit_accum;
                        nxt.saturated    = nxt.saturated | digit_sat;
                        nxt.mode         = MODE_DIGITS;
                    end else begin
                        nxt.mode = MODE_FAIL;
                    end
                end
                MODE_DIGITS:
                begin
                    nxt.number_accum = digit_accum;
                    nxt.saturated    = nxt.saturated | digit_sat;
                end
                default:
                begin
                    nxt.mode = MODE_FAIL;
                end
            endcase
        end
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svts_pkg::*;

    // Characters the scanner treats specially.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // The directive text, first character in the top byte.
    localparam logic [63:0] VERSION_WORD = "#version";
    // Blanks skipped before the directive, and the wider set skipped before the number.
    localparam logic [31:0] LEAD_BLANKS = {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    localparam logic [47:0] NUM_BLANKS  = {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    // Filler used inside block comments, rich in the characters that close them.
    localparam logic [39:0] BLOCK_FILL  = {CH_STAR, CH_SLASH, 8'h61, CH_SPACE, CH_LF};

    typedef struct packed {
        logic [15:0] version;
        logic        version_line;
        logic        token_found;
        logic [15:0] blank_start;
        logic [15:0] blank_end;
        logic        overflow;
    } summary_t;

    // The scoreboard carries its own copy of the scan state and of the three
    // registers. Every accepted nonzero byte advances the scan; a byte that
    // ends the source turns the state into an expected summary.
    class version_scoreboard;
        logic [15:0] floor_version;
        logic        force_on;
        logic [15:0] forced_version;

        scan_mode_t  mode;
        logic        held;
        logic [15:0] offset;
        logic [2:0]  match_pos;
        logic [15:0] accum;
        logic        negative;
        logic [15:0] token_start;
        logic        clipped;

        summary_t    expected_summaries[$];
        int unsigned mismatches;

        function new();
            floor_version  = MIN_VERSION_RESET;
            force_on       = 1'b0;
            forced_version = 16'd0;
            mismatches     = 0;
            restart();
        endfunction

        function void restart();
            mode        = MODE_BLANK;
            held        = 1'b0;
            offset      = 16'd0;
            match_pos   = 3'd0;
            accum       = 16'd0;
            negative    = 1'b0;
            token_start = 16'd0;
            clipped     = 1'b0;
        endfunction

        function void note_setting(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_MIN_VERSION:  floor_version  = data;
                REG_FORCE_ENABLE: force_on       = data[0];
                REG_FORCE_VALUE:  forced_version = data;
                default: ;
            endcase
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function bit is_num_blank(logic [7:0] b);
            return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
        endfunction

        function void add_digit(logic [7:0] b);
            int unsigned v;
            v = 32'(accum) * 10 + 32'(b) - 32'(CH_ZERO);
            if (v > 65535) begin
                v = 65535;
                clipped = 1'b1;
            end
            accum = 16'(v);
        endfunction

        function void scan_char(logic [7:0] b);
            logic [15:0] here;
            if (mode == MODE_DONE || mode == MODE_FAIL)
                return;
            // The byte after the last digit decides the scan and is not counted.
            if (mode == MODE_DIGITS && !is_digit(b)) begin
                mode = MODE_DONE;
                return;
            end
            here = offset;
            if (offset < OFFSET_CAP)
                offset = offset + 16'd1;
            else
                clipped = 1'b1;
            case (mode)
                MODE_BLANK: begin
                    if (held) begin
                        held = 1'b0;
                        if (b == CH_STAR)
                            mode = MODE_BLOCK;
                        else if (b == CH_SLASH)
                            mode = MODE_LINE;
                        else
                            mode = MODE_FAIL;
                    end
                    else if (b == CH_SLASH)
                        held = 1'b1;
                    else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
                    end
                    else if (b == VERSION_WORD[63:56]) begin
                        mode        = MODE_MATCH;
                        match_pos   = 3'd1;
                        token_start = here;
                    end
                    else
                        mode = MODE_FAIL;
                end
                MODE_LINE: begin
                    if (b == CH_LF)
                        mode = MODE_BLANK;
                end
                MODE_BLOCK: begin
                    if (held && b == CH_SLASH) begin
                        held = 1'b0;
                        mode = MODE_BLANK;
                    end
                    else
                        held = (b == CH_STAR);
                end
                MODE_MATCH: begin
                    if (b == VERSION_WORD[63 - 8 * int'(match_pos) -: 8]) begin
                        if (match_pos == 3'd7) begin
                            match_pos = 3'd0;
                            mode      = MODE_SPACE;
                        end
                        else
                            match_pos = match_pos + 3'd1;
                    end
                    else
                        mode = MODE_FAIL;
                end
                MODE_SPACE: begin
                    if (is_num_blank(b)) begin
                    end
                    else if (b == CH_PLUS || b == CH_MINUS) begin
                        negative = (b == CH_MINUS);
                        mode     = MODE_SIGN;
                    end
                    else if (is_digit(b)) begin
                        add_digit(b);
                        mode = MODE_DIGITS;
                    end
                    else
                        mode = MODE_FAIL;
                end
                MODE_SIGN: begin
                    if (is_digit(b)) begin
                        add_digit(b);
                        mode = MODE_DIGITS;
                    end
                    else
                        mode = MODE_FAIL;
                end
                MODE_DIGITS: add_digit(b);
                default: mode = MODE_FAIL;
            endcase
        endfunction

        // A zero byte ends the source without being scanned.
        function void note_byte(logic [7:0] b, logic fin);
            summary_t    s;
            logic        hit;
            logic [15:0] v;
            if (b != 8'd0)
                scan_char(b);
            if (b != 8'd0 && !fin)
                return;
            hit = (mode == MODE_DIGITS || mode == MODE_DONE);
            v = floor_version;
            if (hit && !negative && accum > floor_version)
                v = accum;
            if (force_on)
                v = forced_version;
            s.version      = v;
            s.version_line = (v != 16'd0);
            s.token_found  = hit;
            s.blank_start  = hit ? token_start : 16'd0;
            s.blank_end    = hit ? offset : 16'd0;
            s.overflow     = clipped;
            expected_summaries.push_back(s);
            restart();
        endfunction

        function int pending();
            return expected_summaries.size();
        endfunction

        task report(string what);
            if (mismatches < 50)
                $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_summary(summary_t got);
            summary_t want;
            if (expected_summaries.size() == 0) begin
                report("summary arrived with no source pending");
                return;
            end
            want = expected_summaries.pop_front();
            if (got.version !== want.version)
                report($sformatf("version %0d, expected %0d", got.version, want.version));
            if (got.version_line !== want.version_line)
                report($sformatf("version_line %0b, expected %0b",
                                 got.version_line, want.version_line));
            if (got.token_found !== want.token_found)
                report($sformatf("token_found %0b, expected %0b",
                                 got.token_found, want.token_found));
            if (got.blank_start !== want.blank_start)
                report($sformatf("blank_start %0d, expected %0d",
                                 got.blank_start, want.blank_start));
            if (got.blank_end !== want.blank_end)
                report($sformatf("blank_end %0d, expected %0d", got.blank_end, want.blank_end));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    svts_byte_if   src_if ();
    svts_result_if res_if ();

    version_scoreboard sb;

    // While calm is set neither side idles.
    bit          calm = 1'b0;
    int unsigned bytes_sent = 0;
    logic [7:0]  text_buf[$];

    shader_version_token_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_if.sink),
        .res       (res_if.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Every summary word taken from the block is checked against the oldest
    // expectation. Outputs are sampled at the edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_summary('{version:      res_if.version,
                               version_line: res_if.version_line,
                               token_found:  res_if.token_found,
                               blank_start:  res_if.blank_start,
                               blank_end:    res_if.blank_end,
                               overflow:     res_if.overflow});
    end

    // The receiving side drops ready at random between runs of ready cycles,
    // and stays ready once the run turns calm.
    initial
    begin
        res_if.ready <= 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
        end
    end

    // Offer one source byte and wait until the block takes the word. The sender
    // sometimes drops valid for a random gap first. Called at a rising edge.
    task automatic send_byte(logic [7:0] b, logic fin);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        src_if.valid    <= 1'b1;
        src_if.src_byte <= b;
        src_if.last     <= fin;
        do
            @(posedge clk);
        while (src_if.ready !== 1'b1);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    // Send the buffered source. It ends either with last on its final byte or
    // with a zero byte, whose own last flag is then random.
    task automatic send_buffer(bit zero_end);
        int n;
        n = text_buf.size();
        if (n == 0)
            zero_end = 1'b1;
        for (int i = 0; i < n; i++)
            send_byte(text_buf[i], !zero_end && i == n - 1);
        if (zero_end)
            send_byte(8'd0, 1'($urandom_range(0, 1)));
        text_buf.delete();
    endtask

    task automatic send_text(string s, bit zero_end);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buffer(zero_end);
    endtask

    // Stop sending and let every summary drain, then wait on so that the block
    // is surely idle before the registers change.
    task automatic quiesce();
        src_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_setting(idx, data);
    endtask

    task automatic program_regs(logic [15:0] floor_v, logic force_e, logic [15:0] force_v);
        cfg_write <= 1'b1;
        write_reg(REG_MIN_VERSION, floor_v);
        write_reg(REG_FORCE_ENABLE, {15'd0, force_e});
        write_reg(REG_FORCE_VALUE, force_v);
        cfg_write <= 1'b0;
    endtask

    // Most random sources are well formed: leading blanks and comments, the
    // directive, number blanks, an optional sign, digits and some trailing text.
    // The rest are raw noise or carry a lone slash, a broken directive or a stray letter.
    function automatic void build_random_source();
        int unsigned n;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10)) text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 4))
                0, 3: text_buf.push_back(LEAD_BLANKS[8 * $urandom_range(0, 3) +: 8]);
                1:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 6))
                        text_buf.push_back(8'($urandom_range(1, 255)));
                    text_buf.push_back(CH_LF);
                end
                2:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6))
                        text_buf.push_back(BLOCK_FILL[8 * $urandom_range(0, 4) +: 8]);
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
                default:
                begin
                    // A slash and a random byte, which fail the scan unless they open a comment.
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : 8;
        for (int i = 0; i < int'(n); i++)
            text_buf.push_back(VERSION_WORD[63 - 8 * i -: 8]);
        if (n < 8)
        begin
            if ($urandom_range(0, 1) == 1)
                text_buf.push_back(8'($urandom_range(8'h41, 8'h7A)));
            return;
        end
        repeat ($urandom_range(0, 3))
            text_buf.push_back(NUM_BLANKS[8 * $urandom_range(0, 5) +: 8]);
        if ($urandom_range(0, 11) == 0)
            text_buf.push_back(8'h78);
        case ($urandom_range(0, 7))
            0: text_buf.push_back(CH_PLUS);
            1: text_buf.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
        repeat (n) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    initial
    begin
        int unsigned phase_start;
        logic [15:0] floor_v;
        logic        force_e;
        logic [15:0] force_v;

        sb = new();
        rst_n           = 1'b0;
        src_if.valid    <= 1'b0;
        src_if.src_byte <= 8'd0;
        src_if.last     <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= REG_MIN_VERSION;
        cfg_data        <= 16'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sources, first with the register values that reset leaves.
        send_text("#version 300 es", 1'b0);
        send_text(" \t\015\n#version 100\n", 1'b1);
        send_text("// line\n/* a ** / */#version\t\013\014+450", 1'b0);
        send_text("#version -5", 1'b0);                  // negative: the floor wins
        send_text("#version 99999", 1'b0);               // the number saturates
        send_text("/", 1'b0);                            // source ends on a lone slash
        send_text("/x#version 310", 1'b0);               // lone slash before text
        send_text("#vers", 1'b0);                        // directive cut short
        send_text("#version ", 1'b0);                    // no digit before the end
        send_text("#version +", 1'b1);
        send_text("#version -x", 1'b0);
        send_text("x", 1'b0);
        send_text("", 1'b1);                             // empty source, zero byte only
        send_text("#version 0330#version 2", 1'b0);      // text after the decision is ignored
        send_text("#version 65535", 1'b0);
        send_text("/* open / *", 1'b0);                  // ends inside a block comment
        send_text("#version 4\200\377", 1'b0);
        send_text("#Version 300", 1'b0);
        send_text("#version\n\n 200", 1'b0);
        send_text("/*/ */\t#version 121", 1'b1);

        // A zero floor lets the reported version itself reach zero.
        quiesce();
        program_regs(16'd0, 1'b0, 16'd0);
        send_text("#version -7", 1'b0);
        send_text("x", 1'b1);
        send_text("#version 0", 1'b0);

        // Forcing a zero version hides a valid source value.
        quiesce();
        program_regs(16'd100, 1'b1, 16'd0);
        send_text("#version 450", 1'b0);

        // Random sources in phases, each under its own register setting. The
        // sender holds off at each phase change until every summary has come.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin floor_v = 16'd0;     force_e = 1'b0; force_v = 16'd0;     end
                1: begin floor_v = 16'hFFFF;  force_e = 1'b0; force_v = 16'd0;     end
                2: begin floor_v = 16'd200;   force_e = 1'b1; force_v = 16'hFFFF;  end
                3: begin floor_v = 16'd0;     force_e = 1'b1; force_v = 16'd0;     end
                4:
                begin
                    floor_v = 16'($urandom_range(0, 65535));
                    force_e = 1'($urandom_range(0, 1));
                    force_v = 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    floor_v = MIN_VERSION_RESET;
                    force_e = 1'b0;
                    force_v = 16'($urandom_range(0, 65535));
                end
            endcase
            quiesce();
            program_regs(floor_v, force_e, force_v);
            // The final phase runs without idling on either side.
            if (p == 5)
                calm = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 100)
            begin
                build_random_source();
                send_buffer($urandom_range(0, 3) == 0);
            end
        end

        // Drain the last summaries and let the block settle before the verdict.
        src_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0)
            $display("shader_version_token_scanner regression: pass");
        else
            $display("shader_version_token_scanner regression: fail");
        $finish;
    end

    // Guard against a hung handshake; the slowest correct run needs far less.
    initial
    begin
        #10ms;
        $display("shader_version_token_scanner regression: fail");
        $finish;
    end

endmodule

>>> files.f
src/svts_pkg.sv
src/svts_if.sv
src/svts_scan_step.sv
src/shader_version_token_scanner.sv
verif/tb_top.sv
